// ===== rtl/concat_requantize_int8_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CONCAT_REQUANTIZE_INT8_CORE_MACROS_SVH
`define CONCAT_REQUANTIZE_INT8_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("concat_requantize_int8_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("concat_requantize_int8_core: next-cycle check failed");

`endif

// ===== rtl/crq_pkg.sv =====
`timescale 1ns / 1ps

package crq_pkg;

    // APB address width: eight 32-bit registers at byte offsets 4*i
    localparam int unsigned ADDR_W = 5;

    // Count limits
    localparam logic [16:0] MAX_PLANE    = 17'd65536;
    localparam logic [10:0] MAX_CHANNELS = 11'd1024;
    localparam logic [8:0]  MAX_BATCH    = 9'd256;

    // Register map
    typedef enum logic [2:0] {
        REG_RATIO_FIRST     = 3'd0,
        REG_RATIO_SECOND    = 3'd1,
        REG_CHANNELS_FIRST  = 3'd2,
        REG_CHANNELS_SECOND = 3'd3,
        REG_PLANE_SIZE      = 3'd4,
        REG_BATCH_COUNT     = 3'd5,
        REG_ACT_MIN         = 3'd6,
        REG_ACT_MAX         = 3'd7
    } crq_reg_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [31:0]        ratio_first;
        logic [31:0]        ratio_second;
        logic [10:0]        channels_first;
        logic [10:0]        channels_second;
        logic [16:0]        plane_size;
        logic [8:0]         batch_count;
        logic signed [7:0]  act_min;
        logic signed [7:0]  act_max;
    } crq_cfg_t;

endpackage

// ===== rtl/crq_regs.sv =====
`timescale 1ns / 1ps

module crq_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output crq_pkg::crq_cfg_t           cfg
);
    import crq_pkg::*;

    crq_cfg_t cfg_reg;
    crq_cfg_t cfg_next;
    crq_reg_t reg_sel;
    logic     wr_en;

    assign reg_sel = crq_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_RATIO_FIRST:     cfg_next.ratio_first     = pwdata;
                REG_RATIO_SECOND:    cfg_next.ratio_second    = pwdata;
                REG_CHANNELS_FIRST:  cfg_next.channels_first  = pwdata[10:0];
                REG_CHANNELS_SECOND: cfg_next.channels_second = pwdata[10:0];
                REG_PLANE_SIZE:      cfg_next.plane_size      = pwdata[16:0];
                REG_BATCH_COUNT:     cfg_next.batch_count     = pwdata[8:0];
                REG_ACT_MIN:         cfg_next.act_min         = signed'(pwdata[7:0]);
                REG_ACT_MAX:         cfg_next.act_max         = signed'(pwdata[7:0]);
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio_first     <= 32'd65536;
            cfg_reg.ratio_second    <= 32'd65536;
            cfg_reg.channels_first  <= 11'd1;
            cfg_reg.channels_second <= 11'd1;
            cfg_reg.plane_size      <= 17'd1;
            cfg_reg.batch_count     <= 9'd1;
            cfg_reg.act_min         <= -8'sd128;
            cfg_reg.act_max         <= 8'sd127;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux, zero extended
    always_comb
    begin
        unique case (reg_sel)
            REG_RATIO_FIRST:     prdata = cfg_reg.ratio_first;
            REG_RATIO_SECOND:    prdata = cfg_reg.ratio_second;
            REG_CHANNELS_FIRST:  prdata = {21'd0, cfg_reg.channels_first};
            REG_CHANNELS_SECOND: prdata = {21'd0, cfg_reg.channels_second};
            REG_PLANE_SIZE:      prdata = {15'd0, cfg_reg.plane_size};
            REG_BATCH_COUNT:     prdata = {23'd0, cfg_reg.batch_count};
            REG_ACT_MIN:         prdata = {24'd0, cfg_reg.act_min};
            REG_ACT_MAX:         prdata = {24'd0, cfg_reg.act_max};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/crq_requant.sv =====
`timescale 1ns / 1ps

module crq_requant (
    input  logic signed [7:0]  sample,
    input  logic [31:0]        ratio,
    input  logic signed [7:0]  act_min,
    input  logic signed [7:0]  act_max,
    output logic signed [7:0]  value
);
    import crq_pkg::*;

    logic [7:0]        abs_s;
    logic [39:0]       product;
    logic [23:0]       quot;
    logic [15:0]       rem;
    logic              round_up;
    logic [24:0]       q_rnd;
    logic signed [7:0] sat;
    logic signed [7:0] lo_clamped;

    // Magnitude times Q16.16 ratio, exact in 40 bits
    assign abs_s   = sample[7] ? (~sample + 8'd1) : sample;
    assign product = 40'(abs_s) * 40'(ratio);
    assign quot    = product[39:16];
    assign rem     = product[15:0];

    // Round half to even on the magnitude
    assign round_up = (rem > 16'h8000) || ((rem == 16'h8000) && quot[0]);
    assign q_rnd    = {1'b0, quot} + 25'(round_up);

    // Apply sign and saturate to int8
    always_comb
    begin
        if (sample[7])
            sat = (q_rnd >= 25'd128) ? -8'sd128 : signed'(~q_rnd[7:0] + 8'd1);
        else
            sat = (q_rnd >= 25'd127) ? 8'sd127 : signed'(q_rnd[7:0]);
    end

    // Activation clamp, upper bound last
    assign lo_clamped = (sat < act_min) ? act_min : sat;
    assign value      = (lo_clamped > act_max) ? act_max : lo_clamped;

endmodule

// ===== rtl/concat_requantize_int8_core.sv =====
`timescale 1ns / 1ps
// An accepted sample is registered in the input stage, then in the result stage;
// the input register and the result register form a two-deep pipeline. One sample
// per cycle unless stalled: input stalls only when both hold items and out_ready is low.
// Reset (rst_n low, asynchronous): position counters to zero, both pipeline
// stages empty, configuration registers to their default values.
module concat_requantize_int8_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [7:0]           sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [7:0]           value,
    output logic                        tensor_end
);
    import crq_pkg::*;

    crq_cfg_t cfg;

    // Position state
    logic [15:0] plane_pos_reg,  plane_pos_next;
    logic [9:0]  chan_idx_reg,   chan_idx_next;
    logic        src_sel_reg,    src_sel_next;
    logic [7:0]  batch_idx_reg,  batch_idx_next;

    // Input stage
    logic              s1_valid_reg;
    logic signed [7:0] s1_sample_reg;
    logic [31:0]       s1_ratio_reg;
    logic              s1_end_reg;

    // Result stage
    logic              out_valid_reg;
    logic signed [7:0] value_reg;
    logic              tensor_end_reg;

    logic              accept;
    logic              out_load;
    logic signed [7:0] rq_value;

    logic [16:0] plane_lim;
    logic [10:0] chan_cfg;
    logic [10:0] chan_lim;
    logic [8:0]  batch_lim;
    logic        end_plane;
    logic        end_chan;
    logic        end_batch;
    logic        end_tensor;

    crq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Handshake: result stage loads when empty or drained this cycle
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    // Limited counts
    assign plane_lim = (cfg.plane_size == 17'd0) ? 17'd1 :
                       (cfg.plane_size > MAX_PLANE) ? MAX_PLANE : cfg.plane_size;
    assign chan_cfg  = src_sel_reg ? cfg.channels_second : cfg.channels_first;
    assign chan_lim  = (chan_cfg == 11'd0) ? 11'd1 :
                       (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chan_cfg;
    assign batch_lim = (cfg.batch_count == 9'd0) ? 9'd1 :
                       (cfg.batch_count > MAX_BATCH) ? MAX_BATCH : cfg.batch_count;

    // Wrap detection; a counter at or past its limit counts as last
    assign end_plane  = ({1'b0, plane_pos_reg} + 17'd1) >= plane_lim;
    assign end_chan   = end_plane && (({1'b0, chan_idx_reg} + 11'd1) >= chan_lim);
    assign end_batch  = end_chan && src_sel_reg;
    assign end_tensor = end_batch && (({1'b0, batch_idx_reg} + 9'd1) >= batch_lim);

    // Counter advance on each input transfer
    always_comb
    begin
        plane_pos_next = plane_pos_reg;
        chan_idx_next  = chan_idx_reg;
        src_sel_next   = src_sel_reg;
        batch_idx_next = batch_idx_reg;
        if (accept)
        begin
            if (!end_plane)
            begin
                plane_pos_next = plane_pos_reg + 16'd1;
            end
            else
            begin
                plane_pos_next = 16'd0;
                if (!end_chan)
                begin
                    chan_idx_next = chan_idx_reg + 10'd1;
                end
                else
                begin
                    chan_idx_next = 10'd0;
                    if (!end_batch)
                    begin
                        src_sel_next = 1'b1;
                    end
                    else
                    begin
                        src_sel_next   = 1'b0;
                        batch_idx_next = end_tensor ? 8'd0 : batch_idx_reg + 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_pos_reg <= 16'd0;
            chan_idx_reg  <= 10'd0;
            src_sel_reg   <= 1'b0;
            batch_idx_reg <= 8'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plane_pos_reg <= plane_pos_next;
            chan_idx_reg  <= chan_idx_next;
            src_sel_reg   <= src_sel_next;
            batch_idx_reg <= batch_idx_next;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (!out_valid_reg || out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input stage payload: sample, owning source's ratio, end flag
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_ratio_reg  <= src_sel_reg ? cfg.ratio_second : cfg.ratio_first;
            s1_end_reg    <= end_tensor;
        end
    end

    crq_requant u_requant (
        .sample  (s1_sample_reg),
        .ratio   (s1_ratio_reg),
        .act_min (cfg.act_min),
        .act_max (cfg.act_max),
        .value   (rq_value)
    );

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg      <= rq_value;
            tensor_end_reg <= s1_end_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign tensor_end = tensor_end_reg;

endmodule

// ===== rtl/crq_checker.sv =====
`timescale 1ns / 1ps
`include "concat_requantize_int8_core_macros.svh"

module crq_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [crq_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic [31:0]                 prdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [7:0]           sample,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic signed [7:0]           value,
    input  logic                        tensor_end
);
    import crq_pkg::*;

    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       in_xfer;
    logic       out_xfer;
    logic       ratio_wr;
    logic       ratio_rd;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign ratio_wr = psel && penable && pwrite && pready &&
                      (paddr[ADDR_W-1:2] == REG_RATIO_FIRST);
    assign ratio_rd = psel && !pwrite && (paddr[ADDR_W-1:2] == REG_RATIO_FIRST);

    // Items inside the block: accepted but not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer)
            occ_next = occ_reg + 2'd1;
        else if (!in_xfer && out_xfer)
            occ_next = occ_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 2'd0;
        else
            occ_reg <= occ_next;
    end

    `CRQ_ASSERT_IMP(a_no_invented_result, clk, rst_n, out_valid, occ_reg != 2'd0)
    `CRQ_ASSERT_IMP(a_full_stalls_input, clk, rst_n, (occ_reg == 2'd2) && !out_ready, !in_ready)
    `CRQ_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(tensor_end))
    `CRQ_ASSERT_NEXT(a_input_holds, clk, rst_n, in_valid && !in_ready, in_valid && $stable(sample))
    `CRQ_ASSERT_NEXT(a_ratio_readback, clk, rst_n, ratio_wr, !ratio_rd || (prdata == $past(pwdata)))

endmodule

bind concat_requantize_int8_core crq_checker u_crq_checker (.*);
